// ----- hw/rtl/lkv_pkg.sv -----
// Shared constants and transfer types of the LRU key/value cache.
`default_nettype none
package lkv_pkg;

	localparam int ENTRIES = 16;
	localparam int IDX_W = $clog2(ENTRIES);
	localparam int AGE_W = IDX_W;
	localparam int CNT_W = $clog2(ENTRIES + 1);
	localparam int CAP_W = 5;
	localparam int CMP_W = (CNT_W > CAP_W) ? CNT_W : CAP_W;
	localparam logic [CAP_W-1:0] CAP_RESET = CAP_W'(16);
	localparam logic [31:0] MISS_VALUE = 32'hFFFF_FFFF;

	localparam logic CMD_GET = 1'b0;
	localparam logic CMD_PUT = 1'b1;

	typedef struct packed {
		logic               cmd;
		logic signed [31:0] key;
		logic signed [31:0] write_value;
	} in_item_t;

	typedef struct packed {
		logic               hit;
		logic signed [31:0] read_value;
		logic               evicted;
	} out_item_t;

	typedef struct packed {
		logic load;
		logic scan;
		logic commit;
	} dp_cmd_t;

	typedef struct packed {
		logic scan_last;
	} dp_status_t;

endpackage
`default_nettype wire

// ----- hw/rtl/lkv_ctrl.sv -----
// Sequencing state machine of the LRU key/value cache: accept, scan, commit.
`default_nettype none
module lkv_ctrl import lkv_pkg::*; (
	input  wire logic       clk,
	input  wire logic       arst_n,
	input  wire logic       in_valid,
	output logic            in_stall,
	output logic            out_valid,
	input  wire logic       out_stall,
	output dp_cmd_t         cmd,
	input  wire dp_status_t status
);

	typedef enum logic [1:0] {
		ST_IDLE,
		ST_SCAN,
		ST_COMMIT
	} state_t;

	state_t state_q;
	logic   out_valid_q;
	logic   out_free;

	assign out_free = !out_valid_q || !out_stall;
	assign in_stall = (state_q != ST_IDLE);
	assign out_valid = out_valid_q;

	always_comb begin
		cmd.load = (state_q == ST_IDLE) && in_valid;
		cmd.scan = (state_q == ST_SCAN);
		cmd.commit = (state_q == ST_COMMIT) && out_free;
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= ST_IDLE;
			out_valid_q <= 1'b0;
		end else begin
			if (out_valid_q && !out_stall && !cmd.commit) begin
				out_valid_q <= 1'b0;
			end
			case (state_q)
				ST_IDLE: begin
					if (in_valid) begin
						state_q <= ST_SCAN;
					end
				end
				ST_SCAN: begin
					if (status.scan_last) begin
						state_q <= ST_COMMIT;
					end
				end
				ST_COMMIT: begin
					if (out_free) begin
						out_valid_q <= 1'b1;
						state_q <= ST_IDLE;
					end
				end
				default: begin
					state_q <= ST_IDLE;
				end
			endcase
		end
	end

endmodule
`default_nettype wire

// ----- hw/rtl/lkv_dpath.sv -----
// Entry storage, sequential key search and recency update of the LRU cache.
`default_nettype none
module lkv_dpath import lkv_pkg::*; (
	input  wire logic             clk,
	input  wire logic             arst_n,
	input  wire in_item_t         in_item,
	output out_item_t             out_item,
	input  wire logic             cfg_we,
	input  wire logic [CAP_W-1:0] cfg_wdata,
	input  wire dp_cmd_t          cmd,
	output dp_status_t            status
);

	logic [CAP_W-1:0]        cap_q;
	logic [CNT_W-1:0]        used_q;
	logic [ENTRIES-1:0]      valid_q;
	logic [AGE_W-1:0]        age_q [ENTRIES];
	logic signed [31:0]      key_q [ENTRIES];
	logic signed [31:0]      value_q [ENTRIES];
	in_item_t                req_q;
	out_item_t               out_q;
	logic [IDX_W-1:0]        idx_q;
	logic                    found_q;
	logic [IDX_W-1:0]        found_idx_q;
	logic [AGE_W-1:0]        found_age_q;
	logic                    free_q;
	logic [IDX_W-1:0]        free_idx_q;
	logic                    any_q;
	logic [IDX_W-1:0]        old_idx_q;
	logic [AGE_W-1:0]        old_age_q;

	logic [CAP_W-1:0]        cap_nz;
	logic                    room;
	logic                    do_touch;
	logic                    age_all;
	logic                    do_fill;
	logic                    do_write_kv;
	logic                    do_write_val;
	logic                    is_evict;
	logic [IDX_W-1:0]        slot;
	logic [AGE_W-1:0]        slot_age;

	assign status.scan_last = (idx_q == IDX_W'(ENTRIES - 1));
	assign out_item = out_q;

	always_comb begin
		cap_nz = (cap_q == '0) ? CAP_W'(1) : cap_q;
		room = (CMP_W'(used_q) < CMP_W'(cap_nz)) && (CMP_W'(used_q) < CMP_W'(ENTRIES));
		do_touch = 1'b0;
		age_all = 1'b0;
		do_fill = 1'b0;
		do_write_kv = 1'b0;
		do_write_val = 1'b0;
		is_evict = 1'b0;
		slot = found_idx_q;
		slot_age = found_age_q;
		if (found_q) begin
			do_touch = 1'b1;
			do_write_val = (req_q.cmd == CMD_PUT);
		end else if (req_q.cmd == CMD_PUT) begin
			if (room) begin
				slot = free_idx_q;
				do_touch = 1'b1;
				age_all = 1'b1;
				do_fill = 1'b1;
				do_write_kv = 1'b1;
			end else if (any_q) begin
				slot = old_idx_q;
				slot_age = old_age_q;
				do_touch = 1'b1;
				do_write_kv = 1'b1;
				is_evict = 1'b1;
			end
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			cap_q <= CAP_RESET;
			used_q <= '0;
			valid_q <= '0;
			for (int i = 0; i < ENTRIES; i++) begin
				age_q[i] <= '0;
			end
		end else begin
			if (cfg_we) begin
				cap_q <= cfg_wdata;
			end
			if (cmd.commit && do_touch) begin
				for (int i = 0; i < ENTRIES; i++) begin
					if (IDX_W'(i) == slot) begin
						age_q[i] <= '0;
					end else if (valid_q[i] && (age_all || age_q[i] < slot_age)) begin
						age_q[i] <= age_q[i] + AGE_W'(1);
					end
				end
			end
			if (cmd.commit && do_fill) begin
				valid_q[slot] <= 1'b1;
				used_q <= used_q + CNT_W'(1);
			end
		end
	end

	always_ff @(posedge clk) begin
		if (cmd.load) begin
			req_q <= in_item;
			idx_q <= '0;
			found_q <= 1'b0;
			free_q <= 1'b0;
			any_q <= 1'b0;
		end
		if (cmd.scan) begin
			if (valid_q[idx_q] && key_q[idx_q] == req_q.key && !found_q) begin
				found_q <= 1'b1;
				found_idx_q <= idx_q;
				found_age_q <= age_q[idx_q];
			end
			if (!valid_q[idx_q] && !free_q) begin
				free_q <= 1'b1;
				free_idx_q <= idx_q;
			end
			if (valid_q[idx_q] && (!any_q || age_q[idx_q] > old_age_q)) begin
				any_q <= 1'b1;
				old_idx_q <= idx_q;
				old_age_q <= age_q[idx_q];
			end
			idx_q <= idx_q + IDX_W'(1);
		end
		if (cmd.commit) begin
			out_q.hit <= found_q;
			out_q.evicted <= is_evict;
			out_q.read_value <= (found_q && req_q.cmd == CMD_GET) ?
				value_q[found_idx_q] : MISS_VALUE;
			if (do_write_kv) begin
				key_q[slot] <= req_q.key;
			end
			if (do_write_kv || do_write_val) begin
				value_q[slot] <= req_q.write_value;
			end
		end
	end

endmodule
`default_nettype wire

// ----- hw/rtl/lru_key_value_cache_core.sv -----
// Top level of the fully associative LRU key/value cache.
`default_nettype none
// A get or put transfer is accepted only while the block is idle and then
// runs through these steps in order: taking the request, a key search that
// walks all sixteen slots in turn, and a commit step that writes the entry,
// updates the recency ranks and loads the result register. The result register
// holds a finished result while the output is stalled; the commit cycle waits
// for it to free. Each request gives exactly one result. A get miss and every
// put report read_value as -1. Capacity zero behaves as one and values above
// the entry count as the entry count; the user must write capacity only while
// the block is idle, which the block itself does not enforce.
module lru_key_value_cache_core import lkv_pkg::*; (
	input  wire logic             clk,
	input  wire logic             arst_n,
	input  wire logic             in_valid,
	output logic                  in_stall,
	input  wire in_item_t         in_item,
	output logic                  out_valid,
	input  wire logic             out_stall,
	output out_item_t             out_item,
	input  wire logic             cfg_we,
	input  wire logic [CAP_W-1:0] cfg_wdata
);

	dp_cmd_t    cmd;
	dp_status_t status;

	lkv_ctrl u_ctrl (
		.clk       (clk),
		.arst_n    (arst_n),
		.in_valid  (in_valid),
		.in_stall  (in_stall),
		.out_valid (out_valid),
		.out_stall (out_stall),
		.cmd       (cmd),
		.status    (status)
	);

	lkv_dpath u_dpath (
		.clk       (clk),
		.arst_n    (arst_n),
		.in_item   (in_item),
		.out_item  (out_item),
		.cfg_we    (cfg_we),
		.cfg_wdata (cfg_wdata),
		.cmd       (cmd),
		.status    (status)
	);

endmodule
`default_nettype wire
